>>> sv/rls_pkg.sv
// Shared types, constants and color conversion for the RGB555 LED strip serializer.
package rls_pkg;

    localparam logic [15:0] MARKER    = 16'h8000;
    localparam int          HDR_BITS  = 32;
    localparam int          WORD_BITS = 16;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_SHOW  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        t_op         op;
        logic [7:0]  idx;
        logic        last;
        logic [15:0] word;
    } t_cmd;

    typedef struct packed {
        logic data_pin;
        logic clock_pulse;
        logic accepted;
        logic sending;
    } t_res;

    // floor(x*31/255), using y/255 = (y + (y>>8) + 1) >> 8 for y < 65535
    function automatic logic [4:0] to_five(input logic [7:0] x);
        logic [13:0] y;
        logic [13:0] q;
        begin
            y = ({6'd0, x} << 5) - {6'd0, x};
            q = (y + (y >> 8) + 14'd1) >> 8;
            to_five = q[4:0];
        end
    endfunction

endpackage

>>> sv/rls_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module rls_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/rls_fifo.sv
// Two-entry register queue used between front, back and result ports.
module rls_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_din,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_dout,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic [1:0]   n_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_dout  = r_mem[r_rp];
    assign n_cnt   = r_cnt + 2'(do_push) - 2'(do_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

endmodule

>>> sv/rls_front.sv
// Front end: input handshake, op decode and RGB888 to RGB555 packing.
module rls_front (
    input  logic         push,
    output logic         full,
    input  logic         i_busy,
    input  logic         i_q_full,
    output logic         o_q_push,
    input  logic [1:0]   i_op,
    input  logic [7:0]   i_pixel_index,
    input  logic [7:0]   i_red,
    input  logic [7:0]   i_green,
    input  logic [7:0]   i_blue,
    input  logic         i_frame_last,
    output rls_pkg::t_cmd o_cmd
);
    import rls_pkg::*;

    assign full     = i_q_full || i_busy;
    assign o_q_push = push && !full;

    always_comb begin
        o_cmd.op   = t_op'(i_op);
        o_cmd.idx  = i_pixel_index;
        o_cmd.last = i_frame_last;
        o_cmd.word = MARKER | {1'b0, to_five(i_green), to_five(i_red), to_five(i_blue)};
    end

endmodule

>>> sv/rls_back.sv
// Back end: frame sequencer, pixel store and per-beat result generation.
module rls_back #(
    parameter int MAX_LEDS = 256,
    localparam int AW      = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1,
    localparam int CW      = $clog2(MAX_LEDS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_busy,
    input  logic          i_cmd_valid,
    input  rls_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output rls_pkg::t_res o_res
);
    import rls_pkg::*;

    t_phase        r_phase, n_phase;
    logic [5:0]    r_bit, n_bit;
    logic [CW-1:0] r_led, n_led;
    logic [CW-1:0] r_count, n_count;
    logic          r_line, n_line;
    logic [15:0]   r_word, n_word;
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    logic          exec;
    logic          idx_ok;
    logic          wr_ok;
    logic          lvl;
    logic [CW-1:0] led_inc;
    logic [5:0]    bit_inc;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    assign o_busy     = r_clr;
    assign exec       = i_cmd_valid && !i_res_full && !r_clr;
    assign o_cmd_pop  = exec;
    assign o_res_push = exec;

    assign idx_ok  = (32'(i_cmd.idx) < MAX_LEDS);
    assign wr_ok   = (r_phase == PH_DONE) && idx_ok;
    assign led_inc = r_led + 1'b1;
    assign bit_inc = r_bit + 6'd1;
    assign lvl     = r_word[~r_bit[3:0]];

    // prefetch the word of the next LED to go out
    assign ram_raddr = (r_phase == PH_DATA) ? led_inc[AW-1:0] : '0;
    assign ram_we    = r_clr || (exec && (i_cmd.op == OP_WRITE) && wr_ok);
    assign ram_waddr = r_clr ? r_clr_addr : AW'(i_cmd.idx);
    assign ram_wdata = r_clr ? MARKER : i_cmd.word;

    rls_ram #(
        .W     (16),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_led   = r_led;
        n_count = r_count;
        n_line  = r_line;
        n_word  = r_word;
        o_res.data_pin    = r_line;
        o_res.clock_pulse = 1'b0;
        o_res.accepted    = 1'b0;
        if (exec) begin
            case (i_cmd.op)
                OP_TICK: begin
                    o_res.clock_pulse = 1'b1;
                    case (r_phase)
                        PH_START: begin
                            n_led   = '0;
                            n_bit   = '0;
                            n_phase = PH_HEADER;
                        end
                        PH_HEADER: begin
                            o_res.data_pin = 1'b0;
                            n_line         = 1'b0;
                            if (32'(bit_inc) >= HDR_BITS) begin
                                n_led   = '0;
                                n_bit   = '0;
                                n_word  = ram_rdata;
                                n_phase = PH_DATA;
                            end else begin
                                n_bit = bit_inc;
                            end
                        end
                        PH_DATA: begin
                            o_res.data_pin = lvl;
                            n_line         = lvl;
                            if (32'(bit_inc) >= WORD_BITS) begin
                                n_led = led_inc;
                                if (led_inc < r_count) begin
                                    n_bit  = '0;
                                    n_word = ram_rdata;
                                end else begin
                                    n_bit   = bit_inc;
                                    n_line  = 1'b0;
                                    n_phase = PH_DONE;
                                end
                            end else begin
                                n_bit = bit_inc;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_WRITE: begin
                    if (wr_ok) begin
                        o_res.accepted = 1'b1;
                        if (i_cmd.last) begin
                            n_count = CW'({1'b0, i_cmd.idx} + 9'd1);
                            n_phase = PH_START;
                        end
                    end
                end
                OP_SHOW: begin
                    n_phase = PH_START;
                end
                default: begin
                end
            endcase
        end
        o_res.sending = (n_phase != PH_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_bit      <= '0;
            r_led      <= '0;
            r_count    <= CW'(MAX_LEDS);
            r_line     <= 1'b0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_led   <= n_led;
            r_count <= n_count;
            r_line  <= n_line;
            if (r_clr) begin
                if (32'(r_clr_addr) == MAX_LEDS - 1) begin
                    r_clr <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

>>> sv/rgb555_led_strip_serializer.sv
// Top level of the RGB555 two-wire LED strip serializer.
//
//  channel   handshake          beat contents
//  input     push / full        op, pixel_index, red, green, blue, frame_last
//  result    empty / pop        data_pin, clock_pulse, accepted, sending
//
// One beat per cycle sustained while pop is high; beats cross the command and result queues.
// Sequencer runs one command per cycle when results have room; the store reads one LED ahead.
// After reset a clearing pass writes every store entry with full held high.
// Pop low fills the result queue and stops the sequencer; full rises when the command queue fills.
module rgb555_led_strip_serializer #(
    parameter int MAX_LEDS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_op,
    input  logic [7:0] i_pixel_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_frame_last,
    output logic       empty,
    input  logic       pop,
    output logic       o_data_pin,
    output logic       o_clock_pulse,
    output logic       o_accepted,
    output logic       o_sending
);
    import rls_pkg::*;

    t_cmd front_cmd;
    t_cmd back_cmd;
    t_res back_res;
    t_res out_res;
    logic busy;
    logic cq_push, cq_full, cq_pop, cq_empty;
    logic rq_push, rq_full;

    rls_front u_front (
        .push          (push),
        .full          (full),
        .i_busy        (busy),
        .i_q_full      (cq_full),
        .o_q_push      (cq_push),
        .i_op          (i_op),
        .i_pixel_index (i_pixel_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_frame_last  (i_frame_last),
        .o_cmd         (front_cmd)
    );

    rls_fifo #(
        .W ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_din   (front_cmd),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_dout  (back_cmd),
        .o_empty (cq_empty)
    );

    rls_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_busy      (busy),
        .i_cmd_valid (!cq_empty),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (cq_pop),
        .i_res_full  (rq_full),
        .o_res_push  (rq_push),
        .o_res       (back_res)
    );

    rls_fifo #(
        .W ($bits(t_res))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_din   (back_res),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_dout  (out_res),
        .o_empty (empty)
    );

    assign o_data_pin    = out_res.data_pin;
    assign o_clock_pulse = out_res.clock_pulse;
    assign o_accepted    = out_res.accepted;
    assign o_sending     = out_res.sending;

endmodule

>>> sim/tb_rgb555_led_strip_serializer.sv
// Testbench for the RGB555 LED strip serializer: random beats, in-line predictor, scoreboard.
`timescale 1ns / 1ps

module tb_rgb555_led_strip_serializer;
    import rls_pkg::*;

    localparam int NUM_LEDS  = 256;
    localparam int LIVE      = 0;
    localparam int PLAN      = 1;
    localparam int MAX_CYC   = 2_000_000;
    localparam int PRINT_CAP = 30;

    typedef struct packed {
        t_op        op;
        logic [7:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
        logic       drain;
    } t_strip_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] i_op = 2'd0;
    logic [7:0] i_pixel_index = 8'd0;
    logic [7:0] i_red = 8'd0;
    logic [7:0] i_green = 8'd0;
    logic [7:0] i_blue = 8'd0;
    logic       i_frame_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_data_pin;
    logic       o_clock_pulse;
    logic       o_accepted;
    logic       o_sending;

    // two copies of the strip state: one tracks the DUT, one plans the stimulus
    logic [15:0] led_mem [2][NUM_LEDS];
    t_phase      phase_q [2];
    logic [5:0]  bit_pos [2];
    logic [8:0]  led_pos [2];
    logic [8:0]  led_cnt [2];
    logic        line_lvl [2];

    t_strip_beat beat_q [$];
    t_res        line_q [$];

    int          errors = 0;
    int          n_checked = 0;
    int          n_ticks = 0;
    int          n_stored = 0;
    int          n_starts = 0;
    int unsigned cycles = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    int          recv_mode = 0;
    int          mode_left = 0;
    t_strip_beat sent_beat;
    t_res        pin_state;
    t_res        want;

    rgb555_led_strip_serializer #(
        .MAX_LEDS(NUM_LEDS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_op(i_op),
        .i_pixel_index(i_pixel_index),
        .i_red(i_red),
        .i_green(i_green),
        .i_blue(i_blue),
        .i_frame_last(i_frame_last),
        .empty(empty),
        .pop(pop),
        .o_data_pin(o_data_pin),
        .o_clock_pulse(o_clock_pulse),
        .o_accepted(o_accepted),
        .o_sending(o_sending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [4:0] five_bit(logic [7:0] x);
        return 5'((32'(x) * 31) / 255);
    endfunction

    function automatic t_res serialize_beat(int c, t_strip_beat b);
        t_res        r;
        logic [15:0] w;
        r = '0;
        r.data_pin = line_lvl[c];
        case (b.op)
            OP_TICK: begin
                r.clock_pulse = 1'b1;
                case (phase_q[c])
                    PH_START: begin
                        led_pos[c] = 9'd0;
                        bit_pos[c] = 6'd0;
                        phase_q[c] = PH_HEADER;
                    end
                    PH_HEADER: begin
                        r.data_pin = 1'b0;
                        line_lvl[c] = 1'b0;
                        bit_pos[c] = bit_pos[c] + 6'd1;
                        if (bit_pos[c] == HDR_BITS) begin
                            led_pos[c] = 9'd0;
                            bit_pos[c] = 6'd0;
                            phase_q[c] = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        w = led_mem[c][led_pos[c][7:0]];
                        r.data_pin = w[4'd15 - bit_pos[c][3:0]];
                        line_lvl[c] = r.data_pin;
                        bit_pos[c] = bit_pos[c] + 6'd1;
                        if (bit_pos[c] == WORD_BITS) begin
                            led_pos[c] = led_pos[c] + 9'd1;
                            if (led_pos[c] < led_cnt[c]) begin
                                bit_pos[c] = 6'd0;
                            end else begin
                                line_lvl[c] = 1'b0;
                                phase_q[c] = PH_DONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            OP_WRITE: begin
                if (phase_q[c] == PH_DONE) begin
                    led_mem[c][b.idx] = MARKER | {1'b0, five_bit(b.green), five_bit(b.red),
                                                  five_bit(b.blue)};
                    r.accepted = 1'b1;
                    if (b.last) begin
                        led_cnt[c] = {1'b0, b.idx} + 9'd1;
                        phase_q[c] = PH_START;
                    end
                end
            end
            OP_SHOW: phase_q[c] = PH_START;
            default: ;
        endcase
        r.sending = (phase_q[c] != PH_DONE);
        return r;
    endfunction

    function automatic t_strip_beat mk(t_op op, logic [7:0] idx, logic [7:0] red,
                                       logic [7:0] green, logic [7:0] blue, logic last);
        t_strip_beat b;
        b = '{op: op, idx: idx, red: red, green: green, blue: blue, last: last, drain: 1'b0};
        return b;
    endfunction

    function automatic t_strip_beat any_beat(t_op op);
        return mk(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom));
    endfunction

    task automatic add_beat(t_strip_beat b);
        beat_q.push_back(b);
        void'(serialize_beat(PLAN, b));
    endtask

    task automatic ticks_to_done();
        while (phase_q[PLAN] != PH_DONE)
            add_beat(any_beat(OP_TICK));
    endtask

    task automatic report_mismatch(string what, int got_v, int want_v);
        if (errors < PRINT_CAP)
            $display("ERROR cycle %0d result %0d: %s got %0d expected %0d",
                     cycles, n_checked, what, got_v, want_v);
        errors++;
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                sent_beat = beat_q.pop_front();
                pin_state = serialize_beat(LIVE, sent_beat);
                line_q.push_back(pin_state);
                if (sent_beat.op == OP_TICK) n_ticks++;
                if (pin_state.accepted) n_stored++;
                if (sent_beat.op == OP_SHOW || (pin_state.accepted && sent_beat.last))
                    n_starts++;
            end
            if (!(push && full)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (beat_q.size() != 0 &&
                             !(beat_q[0].drain && line_q.size() != 0)) begin
                    i_op          <= beat_q[0].op;
                    i_pixel_index <= beat_q[0].idx;
                    i_red         <= beat_q[0].red;
                    i_green       <= beat_q[0].green;
                    i_blue        <= beat_q[0].blue;
                    i_frame_last  <= beat_q[0].last;
                    push          <= 1'b1;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 30);
                        gap_left = $urandom_range(1, 8);
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver: check each popped beat, stall on a mode pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_checked++;
                if (line_q.size() == 0) begin
                    report_mismatch("unexpected result, data_pin", o_data_pin, 0);
                end else begin
                    want = line_q.pop_front();
                    if (o_data_pin !== want.data_pin)
                        report_mismatch("data_pin", o_data_pin, want.data_pin);
                    if (o_clock_pulse !== want.clock_pulse)
                        report_mismatch("clock_pulse", o_clock_pulse, want.clock_pulse);
                    if (o_accepted !== want.accepted)
                        report_mismatch("accepted", o_accepted, want.accepted);
                    if (o_sending !== want.sending)
                        report_mismatch("sending", o_sending, want.sending);
                end
            end
            if (mode_left == 0) begin
                recv_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            case (recv_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom);
                2: pop <= (mode_left % 4 == 0);
                default: pop <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == MAX_CYC) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, line_q.size());
            $display("** rgb555_led_strip_serializer: FAILED **");
            $finish;
        end
    end

    initial begin
        t_strip_beat b;
        int          n_rand;
        int          sel;
        int          frame_no;

        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < NUM_LEDS; i++)
                led_mem[c][i] = MARKER;
            phase_q[c] = PH_START;
            bit_pos[c] = 6'd0;
            led_pos[c] = 9'd0;
            led_cnt[c] = 9'(NUM_LEDS);
            line_lvl[c] = 1'b0;
        end

        // directed: writes dropped while sending, unused op, start tick, show
        add_beat(mk(OP_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        add_beat(mk(OP_NONE, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1));
        add_beat(mk(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        add_beat(mk(OP_SHOW, 8'hFF, 8'd0, 8'd0, 8'd0, 1'b0));
        ticks_to_done();
        add_beat(mk(OP_NONE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        add_beat(mk(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        // color extremes, then a 4-LED frame interrupted by a show
        add_beat(mk(OP_WRITE, 8'd0, 8'hFF, 8'h00, 8'h00, 1'b0));
        add_beat(mk(OP_WRITE, 8'd1, 8'h00, 8'hFF, 8'h00, 1'b0));
        add_beat(mk(OP_WRITE, 8'd2, 8'h00, 8'h00, 8'hFF, 1'b0));
        add_beat(mk(OP_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        add_beat(mk(OP_WRITE, 8'd3, 8'd1, 8'd254, 8'd128, 1'b1));
        repeat (40) add_beat(any_beat(OP_TICK));
        add_beat(mk(OP_WRITE, 8'd5, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        add_beat(mk(OP_NONE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        add_beat(mk(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        ticks_to_done();
        add_beat(mk(OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
        ticks_to_done();
        add_beat(mk(OP_WRITE, 8'd255, 8'd8, 8'd9, 8'd247, 1'b1));
        ticks_to_done();
        add_beat(mk(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));

        // random frames: pixel loads, a closing write, ticks with noise mixed in
        n_rand = 0;
        frame_no = 0;
        while (n_rand < 900) begin
            repeat ($urandom_range(0, 5)) begin
                b = any_beat(OP_WRITE);
                b.last = 1'b0;
                if ($urandom_range(0, 1) == 1) b.idx = 8'($urandom_range(0, 7));
                add_beat(b);
                n_rand++;
            end
            b = any_beat(OP_WRITE);
            b.last = 1'b1;
            b.idx = 8'($urandom_range(0, 5));
            b.drain = (frame_no % 6 == 0);
            add_beat(b);
            n_rand++;
            frame_no++;
            while (phase_q[PLAN] != PH_DONE) begin
                sel = $urandom_range(0, 99);
                if (sel < 86) b = any_beat(OP_TICK);
                else if (sel < 92) b = any_beat(OP_WRITE);
                else if (sel < 98) b = any_beat(OP_NONE);
                else b = any_beat(OP_SHOW);
                add_beat(b);
                if (b.op == OP_TICK || b.op == OP_SHOW) n_rand++;
            end
            repeat ($urandom_range(0, 3))
                add_beat(any_beat(($urandom_range(0, 1) == 1) ? OP_TICK : OP_NONE));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beat_q.size() != 0 || push) @(posedge i_clk);
        while (line_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d ticks, %0d stored pixels, %0d frame starts (%0d random frames)",
                 n_ticks, n_stored, n_starts, frame_no);
        $display("checked %0d results, %0d mismatches", n_checked, errors);
        if (errors == 0) begin
            $display("** rgb555_led_strip_serializer: PASSED **");
        end else begin
            $display("** rgb555_led_strip_serializer: FAILED **");
        end
        $finish;
    end

endmodule
